// File: hw/rtl/swt_pkg.sv
package swt_pkg;

  localparam int NUM_TIMERS_DEF = 8;
  localparam int TIME_WIDTH_DEF = 32;

  localparam int FUNC_W = 2;
  localparam int IN_TIME_W = 32;
  localparam int SHOT_W = 16;
  localparam int SLOT_W = 3;
  localparam int KIND_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK       = 2'd0,
    FUNC_CREATE     = 2'd1,
    FUNC_REMOVE     = 2'd2,
    FUNC_REMOVE_ALL = 2'd3
  } func_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_CREATE = 2'd0,
    KIND_FIRE   = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_t;

  // Token that walks the row of slot cells, one cell per cycle unless a stall holds the row.
  typedef struct packed {
    logic              valid;
    logic              hit;
    logic              fire;
    logic [SLOT_W-1:0] slot;
  } tok_t;

endpackage

// File: hw/rtl/swt_if.sv
interface swt_in_if;
  import swt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [FUNC_W-1:0]    func;
  logic [IN_TIME_W-1:0] now_ms;
  logic [IN_TIME_W-1:0] start_offset;
  logic [IN_TIME_W-1:0] period;
  logic [SHOT_W-1:0]    shot_count;
  logic [SLOT_W-1:0]    slot_index;

  modport source (
    output valid, func, now_ms, start_offset, period, shot_count, slot_index,
    input  ready
  );
  modport sink (
    input  valid, func, now_ms, start_offset, period, shot_count, slot_index,
    output ready
  );
endinterface

interface swt_out_if;
  import swt_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] result_kind;
  logic [SLOT_W-1:0] result_slot;
  logic              ok;
  logic              last;

  modport source (
    output valid, result_kind, result_slot, ok, last,
    input  ready
  );
  modport sink (
    input  valid, result_kind, result_slot, ok, last,
    output ready
  );
endinterface

// File: hw/rtl/swt_cell.sv
module swt_cell #(
  parameter int TIME_WIDTH = swt_pkg::TIME_WIDTH_DEF,
  parameter int CELL_INDEX = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  swt_pkg::tok_t               tok_i,
  output swt_pkg::tok_t               tok_o,
  input  swt_pkg::func_t              func,
  input  logic [TIME_WIDTH-1:0]       now,
  input  logic [TIME_WIDTH-1:0]       new_deadline,
  input  logic [TIME_WIDTH-1:0]       period,
  input  logic [swt_pkg::SHOT_W-1:0]  shots,
  input  logic [swt_pkg::SLOT_W-1:0]  idx
);
  import swt_pkg::*;

  localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(CELL_INDEX);
  localparam bit ADDRESSABLE = CELL_INDEX < (2 ** SLOT_W);

  logic                  active_r, active_nxt;
  logic [TIME_WIDTH-1:0] dl_r, dl_nxt;
  logic [TIME_WIDTH-1:0] per_r, per_nxt;
  logic [SHOT_W-1:0]     shots_r, shots_nxt;
  logic                  perio_r, perio_nxt;
  tok_t                  tok_r, tok_nxt;

  always_comb begin
    active_nxt = active_r;
    dl_nxt     = dl_r;
    per_nxt    = per_r;
    shots_nxt  = shots_r;
    perio_nxt  = perio_r;
    tok_nxt    = tok_i;
    tok_nxt.fire = 1'b0;
    if (tok_i.valid) begin
      unique case (func)
        FUNC_TICK: begin
          if (active_r && (now > dl_r)) begin
            tok_nxt.fire = 1'b1;
            tok_nxt.slot = MY_SLOT;
            dl_nxt = dl_r + per_r;
            if (!perio_r) begin
              shots_nxt = shots_r - SHOT_W'(1);
              if (shots_r == SHOT_W'(1)) begin
                active_nxt = 1'b0;
              end
            end
          end
        end
        FUNC_CREATE: begin
          if (!tok_i.hit && !active_r) begin
            active_nxt   = 1'b1;
            dl_nxt       = new_deadline;
            per_nxt      = period;
            shots_nxt    = shots;
            perio_nxt    = (shots == '0);
            tok_nxt.hit  = 1'b1;
            tok_nxt.slot = MY_SLOT;
          end
        end
        FUNC_REMOVE: begin
          if (ADDRESSABLE && (idx == MY_SLOT) && active_r) begin
            active_nxt  = 1'b0;
            tok_nxt.hit = 1'b1;
          end
        end
        FUNC_REMOVE_ALL: begin
          active_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      tok_r    <= '0;
    end else if (en) begin
      active_r <= active_nxt;
      tok_r    <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dl_r    <= dl_nxt;
      per_r   <= per_nxt;
      shots_r <= shots_nxt;
      perio_r <= perio_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

// File: hw/rtl/multi_slot_software_timer_table_core.sv
// Channel   Dir  Payload                                                   Transfer
// in_ch     in   func, now_ms, start_offset, period, shot_count, slot_index  valid & ready
// out_ch    out  result_kind, result_slot, ok, last                         valid & ready
//
// For every item a token walks the row of slot cells, one cell per cycle while the
// row is not held, then the flush state delivers the pending final result, if any.
// A tick gives one fire result per expired slot, at most one per cycle.
// rst_n is synchronous and clears all slots and the control state.
// When out_ch is stalled with a result waiting, the whole row of cells holds.
module multi_slot_software_timer_table_core #(
  parameter int NUM_TIMERS = swt_pkg::NUM_TIMERS_DEF,
  parameter int TIME_WIDTH = swt_pkg::TIME_WIDTH_DEF
) (
  input logic      clk,
  input logic      rst_n,
  swt_in_if.sink   in_ch,
  swt_out_if.source out_ch
);
  import swt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WALK  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t                state_r, state_nxt;
  func_t                 func_r, func_nxt;
  logic [TIME_WIDTH-1:0] now_r, now_nxt;
  logic [TIME_WIDTH-1:0] ndl_r, ndl_nxt;
  logic [TIME_WIDTH-1:0] per_r, per_nxt;
  logic [SHOT_W-1:0]     shots_r, shots_nxt;
  logic [SLOT_W-1:0]     idx_r, idx_nxt;
  logic                  tok0_r, tok0_nxt;

  logic                  pend_v_r, pend_v_nxt;
  kind_t                 pend_kind_r, pend_kind_nxt;
  logic [SLOT_W-1:0]     pend_slot_r, pend_slot_nxt;
  logic                  pend_ok_r, pend_ok_nxt;

  logic                  out_valid_r, out_valid_nxt;
  kind_t                 out_kind_r, out_kind_nxt;
  logic [SLOT_W-1:0]     out_slot_r, out_slot_nxt;
  logic                  out_ok_r, out_ok_nxt;
  logic                  out_last_r, out_last_nxt;

  tok_t                  tok_chain [NUM_TIMERS+1];
  tok_t                  end_tok;
  logic                  en;
  logic                  fire_any;
  logic [SLOT_W-1:0]     fire_slot;

  assign en = !out_valid_r || out_ch.ready;
  assign tok_chain[0] = '{valid: tok0_r, hit: 1'b0, fire: 1'b0, slot: '0};
  assign end_tok = tok_chain[NUM_TIMERS];

  for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
    swt_cell #(
      .TIME_WIDTH (TIME_WIDTH),
      .CELL_INDEX (g)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .en           (en),
      .tok_i        (tok_chain[g]),
      .tok_o        (tok_chain[g+1]),
      .func         (func_r),
      .now          (now_r),
      .new_deadline (ndl_r),
      .period       (per_r),
      .shots        (shots_r),
      .idx          (idx_r)
    );
  end

  always_comb begin
    fire_any  = 1'b0;
    fire_slot = '0;
    for (int i = 1; i <= NUM_TIMERS; i++) begin
      if (tok_chain[i].valid && tok_chain[i].fire) begin
        fire_any  = 1'b1;
        fire_slot = fire_slot | tok_chain[i].slot;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    now_nxt       = now_r;
    ndl_nxt       = ndl_r;
    per_nxt       = per_r;
    shots_nxt     = shots_r;
    idx_nxt       = idx_r;
    tok0_nxt      = tok0_r;
    pend_v_nxt    = pend_v_r;
    pend_kind_nxt = pend_kind_r;
    pend_slot_nxt = pend_slot_r;
    pend_ok_nxt   = pend_ok_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_kind_nxt  = out_kind_r;
    out_slot_nxt  = out_slot_r;
    out_ok_nxt    = out_ok_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          func_nxt  = func_t'(in_ch.func);
          now_nxt   = TIME_WIDTH'(in_ch.now_ms);
          ndl_nxt   = TIME_WIDTH'(in_ch.now_ms) + TIME_WIDTH'(in_ch.start_offset);
          per_nxt   = TIME_WIDTH'(in_ch.period);
          shots_nxt = in_ch.shot_count;
          idx_nxt   = in_ch.slot_index;
          tok0_nxt  = 1'b1;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (en) begin
          tok0_nxt = 1'b0;
          if (fire_any) begin
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = pend_kind_r;
              out_slot_nxt  = pend_slot_r;
              out_ok_nxt    = pend_ok_r;
              out_last_nxt  = 1'b0;
            end
            pend_v_nxt    = 1'b1;
            pend_kind_nxt = KIND_FIRE;
            pend_slot_nxt = fire_slot;
            pend_ok_nxt   = 1'b1;
          end
          if (end_tok.valid) begin
            state_nxt = ST_FLUSH;
            if (func_r == FUNC_CREATE) begin
              pend_v_nxt    = 1'b1;
              pend_kind_nxt = KIND_CREATE;
              pend_slot_nxt = end_tok.hit ? end_tok.slot : '0;
              pend_ok_nxt   = end_tok.hit;
            end else if (func_r == FUNC_REMOVE) begin
              pend_v_nxt    = 1'b1;
              pend_kind_nxt = KIND_REMOVE;
              pend_slot_nxt = idx_r;
              pend_ok_nxt   = end_tok.hit;
            end
          end
        end
      end
      ST_FLUSH: begin
        if (en) begin
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = pend_kind_r;
            out_slot_nxt  = pend_slot_r;
            out_ok_nxt    = pend_ok_r;
            out_last_nxt  = 1'b1;
          end
          pend_v_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tok0_r      <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tok0_r      <= tok0_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    now_r       <= now_nxt;
    ndl_r       <= ndl_nxt;
    per_r       <= per_nxt;
    shots_r     <= shots_nxt;
    idx_r       <= idx_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_slot_r <= pend_slot_nxt;
    pend_ok_r   <= pend_ok_nxt;
    out_kind_r  <= out_kind_nxt;
    out_slot_r  <= out_slot_nxt;
    out_ok_r    <= out_ok_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_kind = out_kind_r;
  assign out_ch.result_slot = out_slot_r;
  assign out_ch.ok          = out_ok_r;
  assign out_ch.last        = out_last_r;

endmodule

// File: hw/rtl/swt_checker.sv
module swt_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [swt_pkg::KIND_W-1:0] out_kind,
  input logic [swt_pkg::SLOT_W-1:0] out_slot,
  input logic                       out_ok,
  input logic                       out_last
);
  import swt_pkg::*;

  // Only one item is in flight, so a transfer in closes the input side.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item was still in flight");

  a_fire_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_FIRE) |-> out_ok)
    else $error("fire result without ok");

  // Create and remove answers are always the only result of their item.
  a_answer_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_FIRE) |-> out_last)
    else $error("create or remove answer not marked last");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable({out_kind, out_slot, out_ok, out_last}))
    else $error("stalled result changed");

endmodule

bind multi_slot_software_timer_table_core swt_checker u_swt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.result_kind),
  .out_slot  (out_ch.result_slot),
  .out_ok    (out_ch.ok),
  .out_last  (out_ch.last)
);
